// ===== hdl/bced_pkg.sv =====
// Shared types and constants of the button click event detector.
`timescale 1ns / 1ps

package bced_pkg;

   localparam int STAMP_W      = 32;
   localparam int DELAY_W      = 16;
   localparam int CSR_ADDR_W   = 4;
   localparam int EVENT_W      = 3;
   localparam int BOUNCE_W     = 2;
   localparam int TALLY_W      = 2;
   localparam int DEBOUNCE_RUN_DEF = 3;

   localparam logic [DELAY_W-1:0] SINGLE_CLICK_DELAY_RST   = 16'd300;
   localparam logic [DELAY_W-1:0] LONG_PRESS_TIME_RST      = 16'd1000;
   localparam logic [DELAY_W-1:0] LONG_PRESS_HOLD_TIME_RST = 16'd500;
   localparam logic [DELAY_W-1:0] DOUBLE_CLICK_TIME_RST    = 16'd300;

   localparam logic [TALLY_W-1:0] TALLY_MAX = 2'd3;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WAIT_LONG,
      MODE_WAIT_DECISION,
      MODE_LONG
   } mode_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_SINGLE     = 3'd0,
      EV_DOUBLE     = 3'd1,
      EV_LONG_START = 3'd2,
      EV_LONG_HOLD  = 3'd3,
      EV_LONG_STOP  = 3'd4,
      EV_PRESSING   = 3'd5,
      EV_RELEASED   = 3'd6
   } event_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SINGLE_CLICK_DELAY   = 4'd0,
      CSR_LONG_PRESS_TIME      = 4'd1,
      CSR_LONG_PRESS_HOLD_TIME = 4'd2,
      CSR_DOUBLE_CLICK_TIME    = 4'd3
   } csr_addr_type;

   typedef struct packed {
      event_type code;
      logic      pressed;
      logic      long_pressed;
      logic      last;
   } ev_entry_type;

endpackage

// ===== hdl/bced_if.sv =====
// Valid/ready channel interfaces of the button click event detector.
`timescale 1ns / 1ps

interface bced_req_if import bced_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               raw_level;
   logic [STAMP_W-1:0] now_ms;

   modport source (output valid, raw_level, now_ms, input ready);
   modport sink   (input valid, raw_level, now_ms, output ready);
endinterface

interface bced_rsp_if import bced_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_code;
   logic               is_pressed;
   logic               is_long_pressed;
   logic               last_of_run;

   modport source (output valid, event_code, is_pressed, is_long_pressed, last_of_run,
                   input ready);
   modport sink   (input valid, event_code, is_pressed, is_long_pressed, last_of_run,
                   output ready);
endinterface

interface bced_csr_if import bced_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [DELAY_W-1:0]    data;

   modport source (output valid, addr, data, input ready);
   modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hdl/button_click_event_detector.sv =====
// Button click event detector: debounce, click state machine and event output queue.
//
// Usage:
//   req_bus carries one raw button sample (raw_level) with its millisecond time
//   (now_ms) per beat. Each sample yields zero, one or two event beats on rsp_bus;
//   last_of_run marks the final event of a sample.
//   csr_bus writes the four 16-bit delay registers (address 0..3, others ignored);
//   it is always ready and should only be used while the block is idle.
// Path: a sample beat is captured in the input register, and its events are then
//   written into the result queue, whose head slot drives rsp_bus.
// Throughput: one sample per cycle while each sample gives at most one event
//   and rsp_ready stays high; a sample with two events occupies the result
//   queue for two beats, so the next sample waits until the second event is popped. The limit is
//   the two-entry result queue, which takes a new sample only once it drains.
// Reset: synchronous, active high; clears the state machine, debounce counter,
//   both channel stages and loads the default delays (300, 1000, 500, 300 ms).
// Stall: when rsp_ready is low the queue holds its events, one sample waits in
//   the input register, and req_ready drops until the queue can take more.
`timescale 1ns / 1ps

module button_click_event_detector import bced_pkg::*; #(
   parameter int DEBOUNCE_RUN = DEBOUNCE_RUN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bced_req_if.sink   req_bus,
   bced_rsp_if.source rsp_bus,
   bced_csr_if.sink   csr_bus
);

   localparam logic [BOUNCE_W-1:0] RUN = DEBOUNCE_RUN[BOUNCE_W-1:0];

   // configuration
   logic [DELAY_W-1:0] single_delay_ff, long_time_ff, hold_time_ff, double_time_ff;

   // input register
   logic               in_valid_ff;
   logic               in_raw_ff;
   logic [STAMP_W-1:0] in_now_ff;

   // detector state
   logic               stable_ff, stable_in;
   logic [BOUNCE_W-1:0] bounce_ff, bounce_in;
   logic [BOUNCE_W-1:0] bounce_sum;
   mode_type           mode_ff, mode_in;
   logic [STAMP_W-1:0] press_ff, press_in;
   logic [STAMP_W-1:0] release_ff, release_in;
   logic [STAMP_W-1:0] hold_ff, hold_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic               pflag_ff, pflag_in;
   logic               lflag_ff, lflag_in;

   // step results
   event_type          ev0, ev1;
   logic [1:0]         ev_n;
   logic [STAMP_W-1:0] since_press, since_release, since_hold;

   // result queue
   ev_entry_type       slot0_ff, slot1_ff;
   logic [1:0]         count_ff;
   logic               pop;
   logic               process;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         single_delay_ff <= SINGLE_CLICK_DELAY_RST;
         long_time_ff    <= LONG_PRESS_TIME_RST;
         hold_time_ff    <= LONG_PRESS_HOLD_TIME_RST;
         double_time_ff  <= DOUBLE_CLICK_TIME_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.addr)
            CSR_SINGLE_CLICK_DELAY:   single_delay_ff <= csr_bus.data;
            CSR_LONG_PRESS_TIME:      long_time_ff    <= csr_bus.data;
            CSR_LONG_PRESS_HOLD_TIME: hold_time_ff    <= csr_bus.data;
            CSR_DOUBLE_CLICK_TIME:    double_time_ff  <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // handshake
   assign pop     = rsp_bus.valid && rsp_bus.ready;
   assign process = in_valid_ff && ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop));
   assign req_bus.ready = !in_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_raw_ff <= req_bus.raw_level;
         in_now_ff <= req_bus.now_ms;
      end
   end

   // elapsed times, wrapping
   assign since_press   = in_now_ff - press_ff;
   assign since_release = in_now_ff - release_ff;
   assign since_hold    = in_now_ff - hold_ff;

   always_comb begin
      stable_in  = stable_ff;
      bounce_in  = 2'd0;
      bounce_sum = bounce_ff + 2'd1;
      if (in_raw_ff != stable_ff) begin
         if (bounce_sum >= RUN) begin
            stable_in = in_raw_ff;
         end else begin
            bounce_in = bounce_sum;
         end
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      press_in   = press_ff;
      release_in = release_ff;
      hold_in    = hold_ff;
      tally_in   = tally_ff;
      pflag_in   = pflag_ff;
      lflag_in   = lflag_ff;
      ev0        = EV_PRESSING;
      ev1        = EV_RELEASED;
      ev_n       = 2'd0;
      unique case (mode_ff)
         MODE_IDLE: begin
            if (stable_in) begin
               pflag_in = 1'b1;
               press_in = in_now_ff;
               mode_in  = MODE_WAIT_LONG;
               ev0      = EV_PRESSING;
               ev_n     = 2'd1;
            end
         end
         MODE_WAIT_LONG: begin
            if (stable_in) begin
               ev_n = 2'd1;
               if (since_press >= {{(STAMP_W-DELAY_W){1'b0}}, long_time_ff}) begin
                  lflag_in = 1'b1;
                  hold_in  = in_now_ff;
                  mode_in  = MODE_LONG;
                  ev0      = EV_LONG_START;
               end else begin
                  ev0 = EV_PRESSING;
               end
            end else begin
               pflag_in   = 1'b0;
               release_in = in_now_ff;
               if ((tally_ff != 2'd0) && (double_time_ff != '0)) begin
                  tally_in = 2'd0;
                  mode_in  = MODE_IDLE;
                  ev0      = EV_DOUBLE;
                  ev1      = EV_RELEASED;
                  ev_n     = 2'd2;
               end else begin
                  if (tally_ff != TALLY_MAX) begin
                     tally_in = tally_ff + 2'd1;
                  end
                  mode_in = MODE_WAIT_DECISION;
                  ev0     = EV_RELEASED;
                  ev_n    = 2'd1;
               end
            end
         end
         MODE_WAIT_DECISION: begin
            if (stable_in) begin
               pflag_in = 1'b1;
               press_in = in_now_ff;
               mode_in  = MODE_WAIT_LONG;
               ev0      = EV_PRESSING;
               ev_n     = 2'd1;
            end else if (since_release >= {{(STAMP_W-DELAY_W){1'b0}}, single_delay_ff}) begin
               tally_in = 2'd0;
               mode_in  = MODE_IDLE;
               ev0      = EV_SINGLE;
               ev_n     = 2'd1;
            end
         end
         MODE_LONG: begin
            if (stable_in) begin
               if (since_hold >= {{(STAMP_W-DELAY_W){1'b0}}, hold_time_ff}) begin
                  hold_in = in_now_ff;
                  ev0     = EV_LONG_HOLD;
                  ev1     = EV_PRESSING;
                  ev_n    = 2'd2;
               end else begin
                  ev0  = EV_PRESSING;
                  ev_n = 2'd1;
               end
            end else begin
               pflag_in = 1'b0;
               lflag_in = 1'b0;
               mode_in  = MODE_IDLE;
               tally_in = 2'd0;
               ev0      = EV_LONG_STOP;
               ev1      = EV_RELEASED;
               ev_n     = 2'd2;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         bounce_ff <= '0;
         mode_ff   <= MODE_IDLE;
         tally_ff  <= '0;
         pflag_ff  <= 1'b0;
         lflag_ff  <= 1'b0;
         press_ff  <= '0;
         release_ff <= '0;
         hold_ff   <= '0;
      end else if (process) begin
         stable_ff <= stable_in;
         bounce_ff <= bounce_in;
         mode_ff   <= mode_in;
         tally_ff  <= tally_in;
         pflag_ff  <= pflag_in;
         lflag_ff  <= lflag_in;
         press_ff  <= press_in;
         release_ff <= release_in;
         hold_ff   <= hold_in;
      end
   end

   // result queue, head in slot0
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else if (process) begin
         count_ff <= ev_n;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         slot0_ff <= '{code: ev0, pressed: pflag_in, long_pressed: lflag_in,
                       last: (ev_n == 2'd1)};
         slot1_ff <= '{code: ev1, pressed: pflag_in, long_pressed: lflag_in, last: 1'b1};
      end else if (pop) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_bus.valid           = (count_ff != 2'd0);
   assign rsp_bus.event_code      = slot0_ff.code;
   assign rsp_bus.is_pressed      = slot0_ff.pressed;
   assign rsp_bus.is_long_pressed = slot0_ff.long_pressed;
   assign rsp_bus.last_of_run     = slot0_ff.last;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_events_queued: assert property (@(posedge clock) disable iff (reset)
      (process && (ev_n != 2'd0)) |=> rsp_bus.valid)
      else $error("processed sample events not queued");

   a_long_flag: assert property (@(posedge clock) disable iff (reset)
      lflag_ff == (mode_ff == MODE_LONG))
      else $error("long press flag disagrees with mode");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDLE) |-> !pflag_ff)
      else $error("pressed flag set while idle");

   a_head_not_last: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !slot0_ff.last)
      else $error("first of two events marked last");

endmodule
